// ===== rtl/mvsm_pkg.sv =====
package mvsm_pkg;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_TICK  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_SAT  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VREAD,
        ST_RAM0,
        ST_RAM1,
        ST_INTERP,
        ST_SCALE,
        ST_ACCUM,
        ST_WRAP,
        ST_DONE
    } t_state;

    localparam logic [15:0] UNITY_GAIN = 16'd32768;
    localparam logic [16:0] MAX_SPAN   = 17'd65536;
    localparam logic signed [15:0] SAT_HI = 16'sd32767;
    localparam logic signed [15:0] SAT_LO = -16'sd32768;

    // one voice table entry
    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] start;
        logic [16:0] span;
        logic [31:0] pos;
        logic [19:0] step;
        logic [15:0] gain;
        logic        wraps;
    } t_voice;

endpackage

// ===== rtl/multi_voice_sample_mixer_unit.sv =====
// Stereo wavetable mixer. Commands are taken when i_start is high and o_busy is low; each
// gives one result strobed on o_done for one cycle, which the receiver cannot stall. A frame
// write, voice start or stop holds o_busy only in ST_DONE, so such requests cannot be taken
// back to back. A tick walks the voice table one entry at a time over a single-port sample
// RAM: an idle voice needs only the voice read, an active voice the voice read, two RAM
// reads, interpolate, gain, add and write back, with extra ST_WRAP steps when a short
// looping clip is passed more than once in one tick; ST_DONE then finishes the tick.
// Sample RAM is not cleared; only written frames may be played.
module multi_voice_sample_mixer_unit #(
    parameter int VOICE_COUNT  = 16,
    parameter int SAMPLE_DEPTH = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  logic [1:0]         i_mode,
    input  logic [15:0]        i_address,
    input  logic signed [15:0] i_sample_left,
    input  logic signed [15:0] i_sample_right,
    input  logic [7:0]         i_voice_id,
    input  logic [16:0]        i_clip_length,
    input  logic [19:0]        i_voice_rate,
    input  logic [15:0]        i_voice_volume,
    input  logic               i_looping,
    output logic               o_done,
    output logic signed [15:0] o_mix_left,
    output logic signed [15:0] o_mix_right,
    output logic [1:0]         o_status,
    output logic [4:0]         o_active_voices
);
    import mvsm_pkg::*;

    localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int AW = $clog2(SAMPLE_DEPTH);
    localparam int CW = $clog2(VOICE_COUNT + 1);

    // memories
    logic [31:0] sample_ram [SAMPLE_DEPTH];
    t_voice      voice_mem  [VOICE_COUNT];

    logic [VOICE_COUNT-1:0] r_active, n_active;
    t_state      r_state, n_state;
    logic [15:0] r_main_vol;
    t_mode       r_mode, n_mode;
    logic [15:0] r_addr, n_addr;
    logic [31:0] r_wsample, n_wsample;
    logic [7:0]  r_id, n_id;
    logic [16:0] r_len, n_len;
    logic [19:0] r_rate, n_rate;
    logic [15:0] r_gain, n_gain;
    logic        r_loop, n_loop;
    logic [VW-1:0] r_vidx, n_vidx;
    t_voice      r_vrd;
    logic [31:0] r_ram_rd;
    logic [31:0] r_w0, n_w0;
    logic        r_has1, n_has1;
    logic signed [16:0] r_il, n_il, r_ir, n_ir;
    logic [31:0] r_g, n_g;
    logic signed [49:0] r_pl, n_pl, r_pr, n_pr;
    logic signed [21:0] r_sl, n_sl, r_sr, n_sr;
    logic [32:0] r_wpos, n_wpos;
    logic        r_done, n_done;
    logic signed [15:0] r_ol, n_ol, r_or, n_or;
    logic [1:0]  r_stat, n_stat;

    // memory port controls
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_addr;
    logic          vm_we, vm_re;
    logic [VW-1:0] vm_waddr, vm_raddr;
    t_voice        vm_wdata;

    always_ff @(posedge i_clk) begin
        if (ram_we) sample_ram[ram_addr] <= r_wsample;
        if (ram_re) r_ram_rd <= sample_ram[ram_addr];
        if (vm_we) voice_mem[vm_waddr] <= vm_wdata;
        if (vm_re) r_vrd <= voice_mem[vm_raddr];
    end

    // tag match kept in flops beside the table
    logic [7:0]             r_tags [VOICE_COUNT];
    logic [VOICE_COUNT-1:0] tag_hit;
    always_ff @(posedge i_clk) begin
        if (vm_we && r_state == ST_DONE) r_tags[vm_waddr] <= r_id;
    end
    always_comb begin
        for (int v = 0; v < VOICE_COUNT; v++) tag_hit[v] = (r_tags[v] == r_id);
    end

    // lowest free slot
    logic          free_ok;
    logic [VW-1:0] free_idx;
    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
            if (!r_active[v]) begin
                free_ok  = 1'b1;
                free_idx = VW'(v);
            end
        end
    end

    logic [15:0] main_g;
    assign main_g = (r_main_vol > UNITY_GAIN) ? UNITY_GAIN : r_main_vol;

    // per-voice position math from the voice read
    logic [15:0] idx;
    logic [16:0] frac_c;
    logic        idx_ok, nxt_ok;
    logic [32:0] pos_sum, end_pos, pos_wrap;
    logic        over;
    assign idx     = r_vrd.pos[31:16];
    assign idx_ok  = ({1'b0, idx} < r_vrd.span);
    assign nxt_ok  = ({1'b0, idx} + 17'd1 < r_vrd.span);
    assign frac_c  = 17'd65536 - {1'b0, r_vrd.pos[15:0]};
    assign pos_sum = {1'b0, r_vrd.pos} + 33'(r_vrd.step);
    assign end_pos = {r_vrd.span, 16'd0};
    assign over    = pos_sum >= end_pos;
    // step < 16 frames and pos < end, so one subtract suffices except tiny spans
    assign pos_wrap = pos_sum - end_pos;

    // a loop passed more than once finishes its wrap in ST_WRAP
    logic [31:0] new_pos;
    logic        new_act;
    always_comb begin
        new_pos = pos_sum[31:0];
        new_act = 1'b1;
        if (over) begin
            if (r_vrd.wraps && r_vrd.span != 17'd0) new_pos = pos_wrap[31:0];
            else begin
                new_pos = '0;
                new_act = 1'b0;
            end
        end
    end
    logic wrap_again;
    assign wrap_again = over && r_vrd.wraps && r_vrd.span != 17'd0 &&
                        ({1'b0, new_pos} >= end_pos);

    logic signed [15:0] s0l, s0r, s1l, s1r;
    assign s0l = r_w0[15:0];
    assign s0r = r_w0[31:16];
    assign s1l = r_has1 ? r_ram_rd[15:0]  : 16'sd0;
    assign s1r = r_has1 ? r_ram_rd[31:16] : 16'sd0;

    logic signed [34:0] lin_l, lin_r;
    assign lin_l = 35'(s0l) * $signed({1'b0, frac_c}) +
                   35'(s1l) * $signed({18'd0, r_vrd.pos[15:0]});
    assign lin_r = 35'(s0r) * $signed({1'b0, frac_c}) +
                   35'(s1r) * $signed({18'd0, r_vrd.pos[15:0]});

    function automatic logic signed [16:0] trunc16(input logic signed [34:0] x);
        logic signed [34:0] t;
        t = (x < 0) ? x + 35'sd65535 : x;
        return 17'(t >>> 16);
    endfunction

    function automatic logic signed [19:0] trunc30(input logic signed [49:0] x);
        logic signed [49:0] t;
        t = (x < 0) ? x + 50'sd1073741823 : x;
        return 20'(t >>> 30);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [21:0] x,
                                                 output logic hit);
        hit = 1'b0;
        if (x > 22'(SAT_HI)) begin hit = 1'b1; return SAT_HI; end
        if (x < 22'(SAT_LO)) begin hit = 1'b1; return SAT_LO; end
        return 16'(x);
    endfunction

    logic [AW-1:0] a0, a1;
    assign a0 = AW'({16'd0, r_vrd.start} + {16'd0, idx});
    assign a1 = AW'({16'd0, r_vrd.start} + {16'd0, idx} + 32'd1);

    logic last_v;
    assign last_v = (r_vidx == VW'(VOICE_COUNT - 1));

    always_comb begin
        logic hl, hr;
        logic signed [15:0] ql, qr;
        n_state = r_state;  n_active = r_active;
        n_mode = r_mode; n_addr = r_addr; n_wsample = r_wsample; n_id = r_id;
        n_len = r_len; n_rate = r_rate; n_gain = r_gain; n_loop = r_loop;
        n_vidx = r_vidx; n_w0 = r_w0; n_has1 = r_has1; n_il = r_il; n_ir = r_ir;
        n_g = r_g; n_pl = r_pl; n_pr = r_pr; n_sl = r_sl; n_sr = r_sr; n_wpos = r_wpos;
        n_done = 1'b0; n_ol = r_ol; n_or = r_or; n_stat = r_stat;
        ram_we = 1'b0; ram_re = 1'b0; ram_addr = AW'(r_addr);
        vm_we = 1'b0; vm_re = 1'b0; vm_waddr = r_vidx; vm_raddr = r_vidx;
        vm_wdata = r_vrd;
        hl = 1'b0; hr = 1'b0; ql = '0; qr = '0;
        o_busy = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_mode = t_mode'(i_mode); n_addr = i_address;
                    n_wsample = {i_sample_right, i_sample_left};
                    n_id = i_voice_id; n_rate = i_voice_rate; n_loop = i_looping;
                    n_len = (i_clip_length == 17'd0) ? 17'd1 :
                            (i_clip_length > MAX_SPAN) ? MAX_SPAN : i_clip_length;
                    n_gain = (i_voice_volume > UNITY_GAIN) ? UNITY_GAIN : i_voice_volume;
                    n_vidx = '0; n_sl = '0; n_sr = '0;
                    n_state = (t_mode'(i_mode) == MODE_TICK) ? ST_VREAD : ST_DONE;
                end
            end
            ST_VREAD: begin
                vm_re = 1'b1;
                n_state = r_active[r_vidx] ? ST_RAM0 : ST_ACCUM;
                if (!r_active[r_vidx]) begin
                    n_state = last_v ? ST_DONE : ST_VREAD;
                    n_vidx = r_vidx + VW'(1);
                end
            end
            ST_RAM0: begin
                ram_addr = a0; ram_re = idx_ok;
                n_has1 = nxt_ok;
                n_state = ST_RAM1;
            end
            ST_RAM1: begin
                n_w0 = idx_ok ? r_ram_rd : 32'd0;
                ram_addr = a1; ram_re = nxt_ok;
                n_g = 32'(r_vrd.gain) * 32'(main_g);
                n_state = ST_INTERP;
            end
            ST_INTERP: begin
                n_il = idx_ok ? trunc16(lin_l) : 17'sd0;
                n_ir = idx_ok ? trunc16(lin_r) : 17'sd0;
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                n_pl = 50'(r_il) * $signed({18'd0, r_g});
                n_pr = 50'(r_ir) * $signed({18'd0, r_g});
                n_state = ST_ACCUM;
            end
            ST_ACCUM: begin
                n_sl = r_sl + 22'(trunc30(r_pl));
                n_sr = r_sr + 22'(trunc30(r_pr));
                if (wrap_again) begin
                    // huge step on a short loop: one subtract per cycle
                    n_wpos = pos_wrap - end_pos;
                    n_state = ST_WRAP;
                end else begin
                    vm_wdata = r_vrd; vm_wdata.pos = new_pos; vm_we = 1'b1;
                    n_active[r_vidx] = new_act;
                    n_vidx = r_vidx + VW'(1);
                    n_state = last_v ? ST_DONE : ST_VREAD;
                end
            end
            ST_WRAP: begin
                if (r_wpos >= end_pos) n_wpos = r_wpos - end_pos;
                else begin
                    vm_wdata = r_vrd; vm_wdata.pos = r_wpos[31:0]; vm_we = 1'b1;
                    n_vidx = r_vidx + VW'(1);
                    n_state = last_v ? ST_DONE : ST_VREAD;
                end
            end
            ST_DONE: begin
                n_done = 1'b1; n_ol = '0; n_or = '0; n_stat = STATUS_OK;
                n_state = ST_IDLE;
                case (r_mode)
                    MODE_WRITE: ram_we = 1'b1;
                    MODE_START: begin
                        if (free_ok) begin
                            vm_we = 1'b1; vm_waddr = free_idx;
                            vm_wdata = '{tag: r_id, start: r_addr, span: r_len, pos: '0,
                                         step: r_rate, gain: r_gain, wraps: r_loop};
                            n_active[free_idx] = 1'b1;
                        end else n_stat = STATUS_FULL;
                    end
                    MODE_STOP: n_active = r_active & ~tag_hit;
                    MODE_TICK: begin
                        ql = sat16(r_sl, hl); qr = sat16(r_sr, hr);
                        n_ol = ql; n_or = qr;
                        if (hl || hr) n_stat = STATUS_SAT;
                    end
                    default: ;
                endcase
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_active <= '0; r_done <= 1'b0;
            r_main_vol <= UNITY_GAIN;
        end else begin
            r_state <= n_state; r_active <= n_active; r_done <= n_done;
            if (i_cfg_we) r_main_vol <= i_cfg_wdata;
        end
        r_mode <= n_mode; r_addr <= n_addr; r_wsample <= n_wsample; r_id <= n_id;
        r_len <= n_len; r_rate <= n_rate; r_gain <= n_gain; r_loop <= n_loop;
        r_vidx <= n_vidx; r_w0 <= n_w0; r_has1 <= n_has1; r_il <= n_il; r_ir <= n_ir;
        r_g <= n_g; r_pl <= n_pl; r_pr <= n_pr; r_sl <= n_sl; r_sr <= n_sr;
        r_wpos <= n_wpos;
        r_ol <= n_ol; r_or <= n_or; r_stat <= n_stat;
    end

    logic [CW-1:0] r_cnt;
    always_ff @(posedge i_clk) r_cnt <= CW'($countones(n_active));

    assign o_done = r_done;
    assign o_mix_left = r_ol;
    assign o_mix_right = r_or;
    assign o_status = r_stat;
    assign o_active_voices = 5'(r_cnt);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == ST_DONE) else $error("strobe without finish");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == STATUS_FULL |-> $stable(r_active)) else $error("drop changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("accept not seen");
endmodule

// ===== tb/tb_multi_voice_sample_mixer_unit.sv =====
`timescale 1ns / 100ps

module tb_multi_voice_sample_mixer_unit;
    import mvsm_pkg::*;

    typedef struct {
        t_mode              mode;
        logic [15:0]        addr;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [7:0]         id;
        logic [16:0]        len;
        logic [19:0]        rate;
        logic [15:0]        vol;
        logic               loop_en;
    } t_request;

    typedef struct {
        logic signed [15:0] mix_l;
        logic signed [15:0] mix_r;
        t_status            status;
        logic [4:0]         active;
    } t_mix_result;

    class mixer_scoreboard;
        logic [31:0]  frame_mem [65536];
        t_voice       voices [16];
        bit           busy_voice [16];
        logic [15:0]  main_vol;
        t_mix_result  pending [$];
        int           mismatches;
        int           n_ticks, n_starts, n_drops, n_sats, n_checked;

        function new();
            main_vol = UNITY_GAIN;
            foreach (voices[v]) begin
                voices[v] = '0;
                busy_voice[v] = 0;
            end
        endfunction

        function longint unsigned clamp_gain(logic [15:0] g);
            return (g > UNITY_GAIN) ? longint'(UNITY_GAIN) : longint'(g);
        endfunction

        function logic [4:0] count_active();
            int n;
            n = 0;
            foreach (busy_voice[v]) if (busy_voice[v]) n++;
            return n[4:0];
        endfunction

        // mix one output frame, then advance every playing voice
        function void mix_frame(ref t_mix_result res);
            longint suml, sumr, mv, g, frac, lv, rv, idx, span;
            longint unsigned npos, span_end;
            logic [31:0] w0, w1;
            bit sat;
            suml = 0;
            sumr = 0;
            sat = 0;
            mv = clamp_gain(main_vol);
            for (int v = 0; v < 16; v++) begin
                if (!busy_voice[v]) continue;
                span = voices[v].span;
                idx = voices[v].pos[31:16];
                if (span == 0 || idx >= span) continue;
                frac = voices[v].pos[15:0];
                w0 = frame_mem[(voices[v].start + idx) & 16'hFFFF];
                w1 = (idx + 1 < span) ? frame_mem[(voices[v].start + idx + 1) & 16'hFFFF] : '0;
                g = longint'(voices[v].gain) * mv;
                lv = (longint'($signed(w0[15:0])) * (65536 - frac)
                      + longint'($signed(w1[15:0])) * frac) / 65536;
                rv = (longint'($signed(w0[31:16])) * (65536 - frac)
                      + longint'($signed(w1[31:16])) * frac) / 65536;
                suml += (lv * g) / 1073741824;
                sumr += (rv * g) / 1073741824;
            end
            if (suml > 32767) begin suml = 32767; sat = 1; end
            if (suml < -32768) begin suml = -32768; sat = 1; end
            if (sumr > 32767) begin sumr = 32767; sat = 1; end
            if (sumr < -32768) begin sumr = -32768; sat = 1; end
            res.mix_l = suml[15:0];
            res.mix_r = sumr[15:0];
            if (sat) begin
                res.status = STATUS_SAT;
                n_sats++;
            end
            for (int v = 0; v < 16; v++) begin
                if (!busy_voice[v]) continue;
                span_end = longint'(voices[v].span) << 16;
                npos = longint'(voices[v].pos) + voices[v].step;
                if (npos >= span_end) begin
                    if (voices[v].wraps && span_end != 0) begin
                        npos = npos % span_end;
                    end else begin
                        busy_voice[v] = 0;
                        npos = 0;
                    end
                end
                voices[v].pos = npos[31:0];
            end
        endfunction

        function void note_request(t_request rq);
            t_mix_result res;
            int slot;
            logic [16:0] len;
            res = '{mix_l: 0, mix_r: 0, status: STATUS_OK, active: 0};
            case (rq.mode)
                MODE_WRITE: frame_mem[rq.addr] = {rq.right, rq.left};
                MODE_START: begin
                    n_starts++;
                    slot = -1;
                    for (int v = 0; v < 16; v++)
                        if (!busy_voice[v] && slot < 0) slot = v;
                    if (slot < 0) begin
                        res.status = STATUS_FULL;
                        n_drops++;
                    end else begin
                        len = rq.len;
                        if (len == 0) len = 1;
                        if (len > MAX_SPAN) len = MAX_SPAN;
                        busy_voice[slot] = 1;
                        voices[slot].tag = rq.id;
                        voices[slot].start = rq.addr;
                        voices[slot].span = len;
                        voices[slot].pos = 0;
                        voices[slot].step = rq.rate;
                        voices[slot].gain = 16'(clamp_gain(rq.vol));
                        voices[slot].wraps = rq.loop_en;
                    end
                end
                MODE_STOP: begin
                    for (int v = 0; v < 16; v++)
                        if (busy_voice[v] && voices[v].tag == rq.id) busy_voice[v] = 0;
                end
                default: begin
                    n_ticks++;
                    mix_frame(res);
                end
            endcase
            res.active = count_active();
            pending.push_back(res);
        endfunction

        function void check_result(t_mix_result got);
            t_mix_result exp_r;
            n_checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing outstanding: l=%0d r=%0d st=%0d act=%0d",
                             got.mix_l, got.mix_r, got.status, got.active);
                return;
            end
            exp_r = pending.pop_front();
            if (got.mix_l !== exp_r.mix_l || got.mix_r !== exp_r.mix_r ||
                got.status !== exp_r.status || got.active !== exp_r.active) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: result %0d exp l=%0d r=%0d st=%0d act=%0d, ",
                              "got l=%0d r=%0d st=%0d act=%0d"},
                             n_checked, exp_r.mix_l, exp_r.mix_r, exp_r.status, exp_r.active,
                             got.mix_l, got.mix_r, got.status, got.active);
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASE_ITEMS = 90;
    // voices only play from this window of sample memory, which is written first
    localparam logic [15:0] WIN_BASE = 16'hFFE0;
    localparam int WIN_SIZE = 64;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic               i_cfg_we;
    logic [15:0]        i_cfg_wdata;
    logic [1:0]         i_mode;
    logic [15:0]        i_address;
    logic signed [15:0] i_sample_left;
    logic signed [15:0] i_sample_right;
    logic [7:0]         i_voice_id;
    logic [16:0]        i_clip_length;
    logic [19:0]        i_voice_rate;
    logic [15:0]        i_voice_volume;
    logic               i_looping;
    logic               o_done;
    logic signed [15:0] o_mix_left;
    logic signed [15:0] o_mix_right;
    logic [1:0]         o_status;
    logic [4:0]         o_active_voices;

    mixer_scoreboard sb;
    int cycles;
    logic [15:0] vol_settings [5];

    multi_voice_sample_mixer_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_mode          (i_mode),
        .i_address       (i_address),
        .i_sample_left   (i_sample_left),
        .i_sample_right  (i_sample_right),
        .i_voice_id      (i_voice_id),
        .i_clip_length   (i_clip_length),
        .i_voice_rate    (i_voice_rate),
        .i_voice_volume  (i_voice_volume),
        .i_looping       (i_looping),
        .o_done          (o_done),
        .o_mix_left      (o_mix_left),
        .o_mix_right     (o_mix_right),
        .o_status        (o_status),
        .o_active_voices (o_active_voices)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result('{mix_l: o_mix_left, mix_r: o_mix_right,
                              status: t_status'(o_status), active: o_active_voices});
    end

    task automatic send_request(t_request rq, int gap);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start        <= 1'b1;
        i_mode         <= rq.mode;
        i_address      <= rq.addr;
        i_sample_left  <= rq.left;
        i_sample_right <= rq.right;
        i_voice_id     <= rq.id;
        i_clip_length  <= rq.len;
        i_voice_rate   <= rq.rate;
        i_voice_volume <= rq.vol;
        i_looping      <= rq.loop_en;
        do @(posedge i_clk); while (o_busy);
        sb.note_request(rq);
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_volume(logic [15:0] v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.main_vol = v;
    endtask

    function automatic t_request noise_request(t_mode m);
        t_request rq;
        rq.mode    = m;
        rq.addr    = 16'($urandom);
        rq.left    = 16'($urandom);
        rq.right   = 16'($urandom);
        rq.id      = 8'($urandom);
        rq.len     = 17'($urandom);
        rq.rate    = 20'($urandom);
        rq.vol     = 16'($urandom);
        rq.loop_en = 1'($urandom);
        return rq;
    endfunction

    function automatic t_request start_request(logic [15:0] a, logic [16:0] len,
                                               logic [19:0] rate, logic [15:0] vol,
                                               logic lp, logic [7:0] id);
        t_request rq;
        rq = noise_request(MODE_START);
        rq.addr = a;
        rq.len = len;
        rq.rate = rate;
        rq.vol = vol;
        rq.loop_en = lp;
        rq.id = id;
        return rq;
    endfunction

    function automatic t_request random_request();
        t_request rq;
        int pick;
        int off;
        pick = $urandom_range(0, 99);
        off = $urandom_range(0, WIN_SIZE - 1);
        if (pick < 15) begin
            rq = noise_request(MODE_WRITE);
            rq.addr = WIN_BASE + 16'(off);
        end else if (pick < 40) begin
            rq = noise_request(MODE_START);
            rq.addr = WIN_BASE + 16'(off);
            rq.id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
            // clip stays inside the written window
            case ($urandom_range(0, 9))
                0:       rq.len = 17'd0;
                default: rq.len = 17'($urandom_range(1, WIN_SIZE - off));
            endcase
            case ($urandom_range(0, 5))
                0:       rq.rate = 20'($urandom);
                1:       rq.rate = 20'h10000;
                default: rq.rate = 20'($urandom_range(0, 20'h3FFFF));
            endcase
            if ($urandom_range(0, 2) != 0) rq.vol = 16'($urandom_range(0, 32768));
        end else if (pick < 50) begin
            rq = noise_request(MODE_STOP);
            if ($urandom_range(0, 3) != 0) rq.id = 8'($urandom_range(0, 7));
        end else begin
            rq = noise_request(MODE_TICK);
        end
        return rq;
    endfunction

    initial begin
        t_request rq;
        sb = new();
        cycles = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_mode = MODE_WRITE;
        i_address = '0;
        i_sample_left = '0;
        i_sample_right = '0;
        i_voice_id = '0;
        i_clip_length = '0;
        i_voice_rate = '0;
        i_voice_volume = '0;
        i_looping = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the playback window so no voice can ever fetch an unwritten frame
        for (int a = 0; a < WIN_SIZE; a++) begin
            rq = noise_request(MODE_WRITE);
            rq.addr = WIN_BASE + 16'(a);
            send_request(rq, int'($urandom_range(0, 5)));
        end

        // directed: extreme samples, address wrap, length clamps, gain clamp, full table
        rq = noise_request(MODE_WRITE);
        rq.addr = 16'hFFFF; rq.left = 16'sh7FFF; rq.right = -16'sh8000;
        send_request(rq, int'($urandom_range(0, 5)));
        rq.addr = 16'h0000; rq.left = -16'sh8000; rq.right = 16'sh7FFF;
        send_request(rq, int'($urandom_range(0, 5)));
        send_request(start_request(16'hFFFF, 17'd3, 20'h08000, 16'hFFFF, 1'b1, 8'd9), 1);
        send_request(start_request(16'h0010, 17'd0, 20'h00000, 16'd32768, 1'b0, 8'd1), 0);
        send_request(start_request(WIN_BASE, 17'h1FFFF, 20'hFFFFF, 16'd0, 1'b0, 8'd2), 2);
        send_request(start_request(WIN_BASE, 17'd65536, 20'hFFFFF, 16'd32768, 1'b1, 8'hFF), 0);
        send_request(start_request(16'h0005, 17'd1, 20'h10000, 16'd32768, 1'b0, 8'd3), 3);
        repeat (3) send_request(noise_request(MODE_TICK), int'($urandom_range(0, 5)));
        rq = noise_request(MODE_STOP); rq.id = 8'd200;
        send_request(rq, 0);
        rq.id = 8'd9;
        send_request(rq, 1);
        // long clips are stopped before they leave the window
        rq.id = 8'd2;
        send_request(rq, 0);
        rq.id = 8'hFF;
        send_request(rq, 2);
        for (int k = 0; k < 17; k++)
            send_request(start_request(WIN_BASE + 16'($urandom_range(0, WIN_SIZE - 4)), 17'd4,
                                       20'h04000, 16'd32768, 1'b1, 8'd5), 0);
        send_request(noise_request(MODE_TICK), 0);
        send_request(noise_request(MODE_TICK), 4);
        rq = noise_request(MODE_STOP); rq.id = 8'd5;
        send_request(rq, 0);

        vol_settings[0] = 16'd32768;
        vol_settings[1] = 16'd0;
        vol_settings[2] = 16'hFFFF;
        vol_settings[3] = 16'($urandom_range(1, 32767));
        vol_settings[4] = 16'd32768;
        foreach (vol_settings[p]) begin
            write_volume(vol_settings[p]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // every other chunk runs back to back
                send_request(random_request(),
                             ((k / 20) % 2 == 1) ? 0 : int'($urandom_range(0, 5)));
            end
        end

        wait_drained();
        repeat (150) @(posedge i_clk);
        $display("Covered %0d ticks (%0d saturated), %0d voice starts (%0d dropped on full table)",
                 sb.n_ticks, sb.n_sats, sb.n_starts, sb.n_drops);
        $display("%0d results checked, %0d mismatches", sb.n_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mvsm_pkg.sv
rtl/multi_voice_sample_mixer_unit.sv
tb/tb_multi_voice_sample_mixer_unit.sv
